// ----- rtl/esc_tfp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_tfp_pkg
// Constants and helpers for the motor-controller telemetry frame parser.
// ----------------------------------------------------------------------------
package esc_tfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 6;

  localparam logic [ByteW-1:0] SYNC_FIRST  = 8'hFE;
  localparam logic [ByteW-1:0] SYNC_SECOND = 8'h01;
  localparam logic [ByteW-1:0] DIR_FORWARD = 8'h01;

  // Frame offsets with a fixed meaning
  localparam logic [OffsetW-1:0] OFF_SYNC2    = 6'd2;
  localparam logic [OffsetW-1:0] OFF_HDR_LAST = 6'd7;
  localparam logic [OffsetW-1:0] OFF_THR_MAG  = 6'd9;
  localparam logic [OffsetW-1:0] OFF_THR_DIR  = 6'd11;
  localparam logic [OffsetW-1:0] OFF_RPM_LO   = 6'd13;
  localparam logic [OffsetW-1:0] OFF_RPM_HI   = 6'd14;
  localparam logic [OffsetW-1:0] OFF_VOLT     = 6'd15;
  localparam logic [OffsetW-1:0] OFF_CUR_HI   = 6'd16;
  localparam logic [OffsetW-1:0] OFF_CUR_LO   = 6'd17;
  localparam logic [OffsetW-1:0] OFF_TEMP_HI  = 6'd18;
  localparam logic [OffsetW-1:0] OFF_TEMP_LO  = 6'd19;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_HDR_BAD = 1'b1;

  // Expected fixed header bytes at offsets 2..7, indexed by offset - 2
  function automatic logic [ByteW-1:0] hdr_byte(input logic [2:0] idx);
    logic [ByteW-1:0] val;
    unique case (idx)
      3'd0:    val = 8'h00;
      3'd1:    val = 8'h03;
      3'd2:    val = 8'h30;
      3'd3:    val = 8'h5C;
      3'd4:    val = 8'h17;
      3'd5:    val = 8'h06;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage : esc_tfp_pkg
`default_nettype wire

// ----- rtl/esc_telemetry_frame_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_telemetry_frame_parser
// Byte-wise parser for motor-controller telemetry frames; one result per frame.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. While hunting it waits for the pair
// FE 01, then counts frame offsets, checks the fixed header at offsets 2..7 and
// captures throttle, speed, voltage, current and temperature. The byte at
// offset FRAME_LENGTH-1 loads the result register, so a result appears in the
// cycle after its last byte is accepted. Input is taken every cycle except
// when a result sits in the output register and out_ready is low; the output
// register is the only stall point. With status 1 all other fields read 0.
module esc_telemetry_frame_parser #(
  parameter int unsigned FRAME_LENGTH = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [esc_tfp_pkg::ByteW-1:0]    in_rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_status,
  output logic signed [8:0]                     out_throttle,
  output logic [19:0]                           out_rpm,
  output logic [7:0]                            out_voltage_tenths,
  output logic [15:0]                           out_current_tenths,
  output logic [15:0]                           out_temperature
);
  import esc_tfp_pkg::*;

  localparam logic [OffsetW-1:0] LastOff = OffsetW'(FRAME_LENGTH - 1);

  // Frame state
  logic               in_frame_r, in_frame_nxt;
  logic [ByteW-1:0]   prev_r, prev_nxt;
  logic [OffsetW-1:0] off_r, off_nxt;
  logic               bad_r, bad_nxt;
  logic [7:0]         mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [7:0]         rpm_lo_r, rpm_lo_nxt;
  logic [7:0]         rpm_hi_r, rpm_hi_nxt;
  logic [7:0]         volt_r, volt_nxt;
  logic [15:0]        cur_r, cur_nxt;
  logic [15:0]        temp_r, temp_nxt;

  // Result register
  logic               out_valid_r;
  logic               status_r;
  logic signed [8:0]  throttle_r;
  logic [19:0]        rpm_r;
  logic [7:0]         volt_out_r;
  logic [15:0]        cur_out_r;
  logic [15:0]        temp_out_r;

  logic               in_acc;
  logic               last_byte;
  logic               hdr_off;
  logic [2:0]         hdr_idx;
  logic [15:0]        rpm_word;
  logic [19:0]        rpm_x10;
  logic signed [8:0]  thr_val;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign last_byte = in_frame_r && (off_r >= LastOff);
  assign hdr_off   = (off_r >= OFF_SYNC2) && (off_r <= OFF_HDR_LAST);
  assign hdr_idx   = 3'(off_r - OFF_SYNC2);

  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_nxt     = prev_r;
    off_nxt      = off_r;
    bad_nxt      = bad_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    rpm_lo_nxt   = rpm_lo_r;
    rpm_hi_nxt   = rpm_hi_r;
    volt_nxt     = volt_r;
    cur_nxt      = cur_r;
    temp_nxt     = temp_r;
    if (!in_frame_r) begin
      if (prev_r == SYNC_FIRST && in_rx_byte == SYNC_SECOND) begin
        in_frame_nxt = 1'b1;
        off_nxt      = OFF_SYNC2;
        bad_nxt      = 1'b0;
      end
      prev_nxt = in_rx_byte;
    end else begin
      if (hdr_off) begin
        if (in_rx_byte != hdr_byte(hdr_idx)) begin
          bad_nxt = 1'b1;
        end
      end else begin
        unique case (off_r)
          OFF_THR_MAG: mag_nxt    = in_rx_byte;
          OFF_THR_DIR: neg_nxt    = (in_rx_byte != DIR_FORWARD);
          OFF_RPM_LO:  rpm_lo_nxt = in_rx_byte;
          OFF_RPM_HI:  rpm_hi_nxt = in_rx_byte;
          OFF_VOLT:    volt_nxt   = in_rx_byte;
          OFF_CUR_HI:  cur_nxt    = {in_rx_byte, cur_r[7:0]};
          OFF_CUR_LO:  cur_nxt    = {cur_r[15:8], in_rx_byte};
          OFF_TEMP_HI: temp_nxt   = {in_rx_byte, temp_r[7:0]};
          OFF_TEMP_LO: temp_nxt   = {temp_r[15:8], in_rx_byte};
          default: ;
        endcase
      end
      if (last_byte) begin
        // Drop back to hunting; a sync pair cannot straddle the frame end
        in_frame_nxt = 1'b0;
        off_nxt      = '0;
        prev_nxt     = '0;
      end else begin
        off_nxt = off_r + OffsetW'(1);
      end
    end
  end

  // Result fields come from the state as updated by the last byte
  assign rpm_word = {rpm_hi_nxt, rpm_lo_nxt};
  assign rpm_x10  = {1'b0, rpm_word, 3'b000} + {3'b000, rpm_word, 1'b0};
  assign thr_val  = neg_nxt ? -$signed({1'b0, mag_nxt}) : $signed({1'b0, mag_nxt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= '0;
      off_r      <= '0;
      bad_r      <= 1'b0;
      mag_r      <= '0;
      neg_r      <= 1'b0;
      rpm_lo_r   <= '0;
      rpm_hi_r   <= '0;
      volt_r     <= '0;
      cur_r      <= '0;
      temp_r     <= '0;
    end else if (in_acc) begin
      in_frame_r <= in_frame_nxt;
      prev_r     <= prev_nxt;
      off_r      <= off_nxt;
      bad_r      <= bad_nxt;
      mag_r      <= mag_nxt;
      neg_r      <= neg_nxt;
      rpm_lo_r   <= rpm_lo_nxt;
      rpm_hi_r   <= rpm_hi_nxt;
      volt_r     <= volt_nxt;
      cur_r      <= cur_nxt;
      temp_r     <= temp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_byte) begin
      if (bad_nxt) begin
        status_r   <= STATUS_HDR_BAD;
        throttle_r <= '0;
        rpm_r      <= '0;
        volt_out_r <= '0;
        cur_out_r  <= '0;
        temp_out_r <= '0;
      end else begin
        status_r   <= STATUS_OK;
        throttle_r <= thr_val;
        rpm_r      <= rpm_x10;
        volt_out_r <= volt_nxt;
        cur_out_r  <= cur_nxt;
        temp_out_r <= temp_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_throttle       = throttle_r;
  assign out_rpm            = rpm_r;
  assign out_voltage_tenths = volt_out_r;
  assign out_current_tenths = cur_out_r;
  assign out_temperature    = temp_out_r;

`ifndef SYNTH
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (off_r >= OFF_SYNC2) && (off_r <= LastOff))
    else $error("frame offset out of range");

  a_hunt_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> off_r == '0)
    else $error("offset not cleared while hunting");

  a_sync_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_frame_r && prev_r == SYNC_FIRST && in_rx_byte == SYNC_SECOND
    |=> in_frame_r && off_r == OFF_SYNC2 && !bad_r)
    else $error("sync pair did not open a frame");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_frame_r && off_r == LastOff
    |=> out_valid_r && !in_frame_r && prev_r == '0)
    else $error("last byte did not emit a result and resume hunting");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == STATUS_HDR_BAD
    |-> throttle_r == '0 && rpm_r == '0 && cur_out_r == '0 && temp_out_r == '0)
    else $error("header mismatch result carries data");
`endif

endmodule : esc_telemetry_frame_parser
`default_nettype wire
